/* hw/rtl/battery_level_from_adc_average_unit_macros.svh */
// Assertion macros shared by the battery level RTL.
// BLA_ASSERT expects clk and rst_n in the scope where it is used; BLA_ASSERT_RST uses only clk.
`ifndef BATTERY_LEVEL_FROM_ADC_AVERAGE_UNIT_MACROS_SVH
`define BATTERY_LEVEL_FROM_ADC_AVERAGE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define BLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define BLA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BLA_ASSERT(lbl, prop, msg)
`define BLA_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* hw/rtl/bla_pkg.sv */
package bla_pkg;

  localparam int TABLE_POINTS = 8;
  localparam int SAMPLE_BITS  = 12;
  localparam int MAX_COUNT    = 1024;

  localparam int CNT_W     = $clog2(MAX_COUNT) + 1;
  localparam int SUM_W     = SAMPLE_BITS + $clog2(MAX_COUNT);
  localparam int LEVEL_W   = 8;
  localparam int PROD_W    = SUM_W + LEVEL_W;
  localparam int QUO_W     = SAMPLE_BITS;
  localparam int LVL_STEPS = LEVEL_W;
  localparam int STEP_W    = $clog2(QUO_W + 1);
  localparam int MUL_STEPS = CNT_W;
  localparam int MCNT_W    = $clog2(MUL_STEPS + 1);
  localparam int SEG_W     = $clog2(TABLE_POINTS);
  localparam int SLOT_W    = 16;
  localparam int SLOTS     = 4;
  localparam int WORD_W    = 64;

  localparam int IN_W      = 16;
  localparam int OUT_W     = 24;
  localparam int OUT_PAD   = OUT_W - LEVEL_W - SAMPLE_BITS;
  localparam int IDX_W     = 8;

  localparam logic [IDX_W-1:0] REG_SAMPLE_COUNT = 8'd0;
  localparam logic [IDX_W-1:0] REG_BP_UPPER     = 8'd1;
  localparam logic [IDX_W-1:0] REG_BP_LOWER     = 8'd2;
  localparam logic [IDX_W-1:0] REG_CAPACITY     = 8'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] n;
  } job_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]     level;
    logic [SAMPLE_BITS-1:0] avg;
  } res_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } seq_sts_t;

  function automatic logic [SAMPLE_BITS-1:0] bp_code(input logic [WORD_W-1:0] up,
                                                     input logic [WORD_W-1:0] lo,
                                                     input logic [SEG_W-1:0]  k);
    logic [WORD_W-1:0] w;
    w = (int'(k) < SLOTS) ? up : lo;
    return w[(int'(k) % SLOTS) * SLOT_W +: SAMPLE_BITS];
  endfunction

  function automatic logic [LEVEL_W-1:0] cap_val(input logic [WORD_W-1:0] cap,
                                                 input logic [SEG_W-1:0]  k);
    return cap[int'(k) * LEVEL_W +: LEVEL_W];
  endfunction

endpackage

/* hw/rtl/bla_serial_mul.sv */
module bla_serial_mul (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [bla_pkg::SUM_W-1:0]      mcand,
  input  logic [bla_pkg::CNT_W-1:0]      mplier,
  output logic [bla_pkg::PROD_W-1:0]     prod,
  output bla_pkg::unit_sts_t             sts
);

  logic [bla_pkg::PROD_W-1:0] acc_r, acc_nxt;
  logic [bla_pkg::PROD_W-1:0] mc_r, mc_nxt;
  logic [bla_pkg::CNT_W-1:0]  mp_r, mp_nxt;
  logic [bla_pkg::MCNT_W-1:0] cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;

  // shift-add: one multiplier bit per cycle, LSB first
  always_comb begin
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      mc_nxt   = bla_pkg::PROD_W'(mcand);
      mp_nxt   = mplier;
      cnt_nxt  = bla_pkg::MCNT_W'(bla_pkg::MUL_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mp_r[0]) begin
        acc_nxt = acc_r + mc_r;
      end
      mc_nxt  = {mc_r[bla_pkg::PROD_W-2:0], 1'b0};
      mp_nxt  = {1'b0, mp_r[bla_pkg::CNT_W-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == bla_pkg::MCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign prod     = acc_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

/* hw/rtl/bla_serial_div.sv */
module bla_serial_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bla_pkg::PROD_W-1:0]  dividend,
  input  logic [bla_pkg::PROD_W-1:0]  divisor,
  input  logic [bla_pkg::STEP_W-1:0]  steps,
  output logic [bla_pkg::QUO_W-1:0]   quo,
  output logic [bla_pkg::PROD_W-1:0]  rem,
  output bla_pkg::unit_sts_t          sts
);

  logic [bla_pkg::PROD_W-1:0] rem_r, rem_nxt;
  logic [bla_pkg::PROD_W-1:0] dv_r, dv_nxt;
  logic [bla_pkg::QUO_W-1:0]  quo_r, quo_nxt;
  logic [bla_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic                       fits;

  assign fits = (rem_r >= dv_r);

  // restoring division: divisor starts pre-shifted, one quotient bit per cycle
  always_comb begin
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = dividend;
      dv_nxt   = divisor;
      quo_nxt  = '0;
      cnt_nxt  = steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = rem_r - dv_r;
      end
      quo_nxt = {quo_r[bla_pkg::QUO_W-2:0], fits};
      dv_nxt  = {1'b0, dv_r[bla_pkg::PROD_W-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == bla_pkg::STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quo      = quo_r;
  assign rem      = rem_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

/* hw/rtl/bla_level_seq.sv */
`include "battery_level_from_adc_average_unit_macros.svh"

module bla_level_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        job_valid,
  input  bla_pkg::job_t               job,
  input  logic [bla_pkg::WORD_W-1:0]  bp_upper,
  input  logic [bla_pkg::WORD_W-1:0]  bp_lower,
  input  logic [bla_pkg::WORD_W-1:0]  cap_points,
  input  logic                        res_ready,
  output bla_pkg::seq_sts_t           sts,
  output bla_pkg::res_t               res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_AVG  = 3'd1;
  localparam logic [2:0] S_SEL  = 3'd2;
  localparam logic [2:0] S_LO   = 3'd3;
  localparam logic [2:0] S_DEN  = 3'd4;
  localparam logic [2:0] S_NUM  = 3'd5;
  localparam logic [2:0] S_QUO  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  localparam logic [bla_pkg::SEG_W-1:0] SEG_LAST = bla_pkg::SEG_W'(bla_pkg::TABLE_POINTS - 1);

  logic [2:0]                      state_r, state_nxt;
  logic [bla_pkg::SUM_W-1:0]       sum_r, sum_nxt;
  logic [bla_pkg::CNT_W-1:0]       n_r, n_nxt;
  logic [bla_pkg::QUO_W-1:0]       avg_r, avg_nxt;
  logic                            rzero_r, rzero_nxt;
  logic [bla_pkg::SEG_W-1:0]       seg_r, seg_nxt;
  logic [bla_pkg::SUM_W-1:0]       diff_r, diff_nxt;
  logic [bla_pkg::SUM_W-1:0]       den_r, den_nxt;
  logic [bla_pkg::LEVEL_W-1:0]     level_r, level_nxt;

  logic                            mul_start;
  logic [bla_pkg::SUM_W-1:0]       mul_mcand;
  logic [bla_pkg::CNT_W-1:0]       mul_mplier;
  logic [bla_pkg::PROD_W-1:0]      mul_prod;
  bla_pkg::unit_sts_t              mul_sts;

  logic                            div_start;
  logic [bla_pkg::PROD_W-1:0]      div_dividend;
  logic [bla_pkg::PROD_W-1:0]      div_divisor;
  logic [bla_pkg::STEP_W-1:0]      div_steps;
  logic [bla_pkg::QUO_W-1:0]       div_quo;
  logic [bla_pkg::PROD_W-1:0]      div_rem;
  bla_pkg::unit_sts_t              div_sts;

  logic                            found;
  logic [bla_pkg::SEG_W-1:0]       seg_sel;
  logic [bla_pkg::SEG_W-1:0]       seg_r_lo;
  logic [bla_pkg::SAMPLE_BITS-1:0] bp_first, bp_last, bp_hi, bp_lo, bp_sel_lo;
  logic [bla_pkg::LEVEL_W-1:0]     cap_hi, cap_lo, cap_mag;
  logic                            cap_neg;
  logic [bla_pkg::LEVEL_W+1:0]     interp;
  logic [bla_pkg::LEVEL_W-1:0]     level_interp;

  bla_serial_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .prod   (mul_prod),
    .sts    (mul_sts)
  );

  bla_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .quo      (div_quo),
    .rem      (div_rem),
    .sts      (div_sts)
  );

  assign seg_r_lo  = seg_r + 1'b1;
  assign bp_first  = bla_pkg::bp_code(bp_upper, bp_lower, '0);
  assign bp_last   = bla_pkg::bp_code(bp_upper, bp_lower, SEG_LAST);
  assign bp_hi     = bla_pkg::bp_code(bp_upper, bp_lower, seg_r);
  assign bp_lo     = bla_pkg::bp_code(bp_upper, bp_lower, seg_r_lo);
  assign bp_sel_lo = bla_pkg::bp_code(bp_upper, bp_lower, seg_sel + 1'b1);
  assign cap_hi    = bla_pkg::cap_val(cap_points, seg_r);
  assign cap_lo    = bla_pkg::cap_val(cap_points, seg_r_lo);
  assign cap_neg   = (cap_hi < cap_lo);
  assign cap_mag   = cap_neg ? (cap_lo - cap_hi) : (cap_hi - cap_lo);

  // compare the floored mean against each segment; the lowest-index segment wins
  always_comb begin
    found   = 1'b0;
    seg_sel = '0;
    for (int i = bla_pkg::TABLE_POINTS - 2; i >= 0; i--) begin
      if ((avg_r < bla_pkg::bp_code(bp_upper, bp_lower, bla_pkg::SEG_W'(i))) &&
          (avg_r >= bla_pkg::bp_code(bp_upper, bp_lower, bla_pkg::SEG_W'(i + 1)))) begin
        found   = 1'b1;
        seg_sel = bla_pkg::SEG_W'(i);
      end
    end
  end

  // quotient magnitude toward zero, then offset from the lower capacity
  always_comb begin
    if (cap_neg) begin
      interp = {2'b00, cap_lo} - {2'b00, div_quo[bla_pkg::LVL_STEPS-1:0]};
    end else begin
      interp = {2'b00, cap_lo} + {2'b00, div_quo[bla_pkg::LVL_STEPS-1:0]};
    end
    if (interp[bla_pkg::LEVEL_W+1]) begin
      level_interp = '0;
    end else if (interp[bla_pkg::LEVEL_W]) begin
      level_interp = '1;
    end else begin
      level_interp = interp[bla_pkg::LEVEL_W-1:0];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    sum_nxt      = sum_r;
    n_nxt        = n_r;
    avg_nxt      = avg_r;
    rzero_nxt    = rzero_r;
    seg_nxt      = seg_r;
    diff_nxt     = diff_r;
    den_nxt      = den_r;
    level_nxt    = level_r;
    mul_start    = 1'b0;
    mul_mcand    = diff_r;
    mul_mplier   = n_r;
    div_start    = 1'b0;
    div_dividend = mul_prod;
    div_divisor  = bla_pkg::PROD_W'(den_r) << (bla_pkg::LVL_STEPS - 1);
    div_steps    = bla_pkg::STEP_W'(bla_pkg::LVL_STEPS);
    unique case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          sum_nxt      = job.sum;
          n_nxt        = job.n;
          div_start    = 1'b1;
          div_dividend = bla_pkg::PROD_W'(job.sum);
          div_divisor  = bla_pkg::PROD_W'(job.n) << (bla_pkg::QUO_W - 1);
          div_steps    = bla_pkg::STEP_W'(bla_pkg::QUO_W);
          state_nxt    = S_AVG;
        end
      end
      S_AVG: begin
        if (div_sts.done) begin
          avg_nxt   = div_quo;
          rzero_nxt = (div_rem == '0);
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        state_nxt = S_OUT;
        if (avg_r >= bp_first) begin
          level_nxt = bla_pkg::cap_val(cap_points, '0);
        end else if ((avg_r < bp_last) || ((avg_r == bp_last) && rzero_r)) begin
          level_nxt = bla_pkg::cap_val(cap_points, SEG_LAST);
        end else if (found) begin
          seg_nxt   = seg_sel;
          mul_start = 1'b1;
          mul_mcand = bla_pkg::SUM_W'(bp_sel_lo);
          state_nxt = S_LO;
        end else begin
          level_nxt = '0;
        end
      end
      S_LO: begin
        if (mul_sts.done) begin
          diff_nxt  = sum_r - mul_prod[bla_pkg::SUM_W-1:0];
          mul_start = 1'b1;
          mul_mcand = bla_pkg::SUM_W'(bp_hi - bp_lo);
          state_nxt = S_DEN;
        end
      end
      S_DEN: begin
        if (mul_sts.done) begin
          den_nxt    = mul_prod[bla_pkg::SUM_W-1:0];
          mul_start  = 1'b1;
          mul_mcand  = diff_r;
          mul_mplier = bla_pkg::CNT_W'(cap_mag);
          state_nxt  = S_NUM;
        end
      end
      S_NUM: begin
        if (mul_sts.done) begin
          div_start = 1'b1;
          state_nxt = S_QUO;
        end
      end
      S_QUO: begin
        if (div_sts.done) begin
          level_nxt = level_interp;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    sum_r   <= sum_nxt;
    n_r     <= n_nxt;
    avg_r   <= avg_nxt;
    rzero_r <= rzero_nxt;
    seg_r   <= seg_nxt;
    diff_r  <= diff_nxt;
    den_r   <= den_nxt;
    level_r <= level_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign sts.idle      = (state_r == S_IDLE);
  assign sts.res_valid = (state_r == S_OUT);
  assign res.level     = level_r;
  assign res.avg       = avg_r;

  `BLA_ASSERT(a_units_exclusive, !(mul_sts.busy && div_sts.busy), "mul and div busy together")
  `BLA_ASSERT(a_level_quo_narrow, (state_r == S_QUO) && div_sts.done |-> div_quo[bla_pkg::QUO_W-1:bla_pkg::LVL_STEPS] == '0, "level quotient overflow")

endmodule

/* hw/rtl/battery_level_from_adc_average_unit.sv */
// Battery level from averaged ADC samples.
// A sample that does not close a batch only adds to the running sum. The last sample of a batch
// reaches out_tvalid after a divider pass for the mean when it falls outside the table or in no
// segment, or after that pass, three shift-add multiplies and a second divider pass when it
// interpolates; in_tready stays low until the result is loaded, which waits on any out stall.
// Reset (rst_n low, synchronous) empties the batch, clears out_tvalid and the table registers, and sets the count to 1.
`include "battery_level_from_adc_average_unit_macros.svh"

module battery_level_from_adc_average_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bla_pkg::IN_W-1:0]      in_tdata,   // [11:0] sample
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bla_pkg::OUT_W-1:0]     out_tdata,  // [7:0] level, [19:8] average_code
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bla_pkg::IDX_W-1:0]     cfg_index,
  input  logic [bla_pkg::WORD_W-1:0]    cfg_data
);

  logic [bla_pkg::CNT_W-1:0]  sample_count_r;
  logic [bla_pkg::WORD_W-1:0] bp_upper_r;
  logic [bla_pkg::WORD_W-1:0] bp_lower_r;
  logic [bla_pkg::WORD_W-1:0] cap_r;
  logic [bla_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [bla_pkg::CNT_W-1:0]  taken_r, taken_nxt;
  logic                       out_tvalid_r;
  logic [bla_pkg::OUT_W-1:0]  out_tdata_r;

  logic [bla_pkg::CNT_W-1:0]  n_eff;
  logic                       in_take;
  logic                       cfg_take;
  logic                       job_valid;
  bla_pkg::job_t              job;
  bla_pkg::seq_sts_t          seq_sts;
  bla_pkg::res_t              res;
  logic                       res_take;

  always_comb begin
    if (sample_count_r == '0) begin
      n_eff = bla_pkg::CNT_W'(1);
    end else if (sample_count_r > bla_pkg::CNT_W'(bla_pkg::MAX_COUNT)) begin
      n_eff = bla_pkg::CNT_W'(bla_pkg::MAX_COUNT);
    end else begin
      n_eff = sample_count_r;
    end
  end

  assign in_tready = seq_sts.idle;
  assign cfg_ready = 1'b1;
  assign in_take   = in_tvalid && in_tready;
  assign cfg_take  = cfg_valid && cfg_ready;

  assign sum_nxt   = sum_r + bla_pkg::SUM_W'(in_tdata[bla_pkg::SAMPLE_BITS-1:0]);
  assign taken_nxt = taken_r + 1'b1;
  assign job_valid = in_take && (taken_nxt >= n_eff);
  assign job.sum   = sum_nxt;
  assign job.n     = n_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= bla_pkg::CNT_W'(1);
      bp_upper_r     <= '0;
      bp_lower_r     <= '0;
      cap_r          <= '0;
      sum_r          <= '0;
      taken_r        <= '0;
    end else begin
      if (cfg_take) begin
        case (cfg_index)
          bla_pkg::REG_SAMPLE_COUNT: begin
            // a new count drops the running batch, unless a sample is taken in the same cycle
            sample_count_r <= cfg_data[bla_pkg::CNT_W-1:0];
            sum_r          <= '0;
            taken_r        <= '0;
          end
          bla_pkg::REG_BP_UPPER: bp_upper_r <= cfg_data;
          bla_pkg::REG_BP_LOWER: bp_lower_r <= cfg_data;
          bla_pkg::REG_CAPACITY: cap_r      <= cfg_data;
          default: ;
        endcase
      end
      if (in_take) begin
        if (job_valid) begin
          sum_r   <= '0;
          taken_r <= '0;
        end else begin
          sum_r   <= sum_nxt;
          taken_r <= taken_nxt;
        end
      end
    end
  end

  bla_level_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (job_valid),
    .job        (job),
    .bp_upper   (bp_upper_r),
    .bp_lower   (bp_lower_r),
    .cap_points (cap_r),
    .res_ready  (!out_tvalid_r || out_tready),
    .sts        (seq_sts),
    .res        (res)
  );

  // load the output register whenever it is empty or being drained
  assign res_take = seq_sts.res_valid && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_tdata_r <= {{bla_pkg::OUT_PAD{1'b0}}, res.avg, res.level};
    end
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_take) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `BLA_ASSERT(a_taken_below_count, taken_r < n_eff, "batch count reached without a result")
  `BLA_ASSERT(a_res_held, seq_sts.res_valid && !res_take |=> seq_sts.res_valid, "result dropped while output stalled")
  `BLA_ASSERT(a_batch_starts_seq, job_valid |=> !seq_sts.idle, "closed batch did not start the sequencer")
  `BLA_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_tvalid_r, "output valid after reset")

endmodule

/* verif/tb_battery_level_from_adc_average_unit.sv */
module tb_battery_level_from_adc_average_unit;
  import bla_pkg::*;

  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_SAMPLES = 28;

  // indexes outside the register map; writes to them change nothing
  localparam logic [IDX_W-1:0] REG_UNMAPPED_LOW  = 8'd4;
  localparam logic [IDX_W-1:0] REG_UNMAPPED_HIGH = 8'd255;

  typedef struct {
    logic [LEVEL_W-1:0]     level;
    logic [SAMPLE_BITS-1:0] average_code;
  } level_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata;   // [11:0] sample
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_W-1:0]    out_tdata;  // [7:0] level, [19:8] average_code
  logic                cfg_valid;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index;
  logic [WORD_W-1:0]   cfg_data;

  // shadow copy of the block's registers and batch state
  logic [CNT_W-1:0]    shadow_count;
  logic [WORD_W-1:0]   shadow_bp_upper;
  logic [WORD_W-1:0]   shadow_bp_lower;
  logic [WORD_W-1:0]   shadow_capacity;
  logic [SUM_W-1:0]    batch_sum;
  logic [CNT_W-1:0]    batch_taken;

  level_result_t       expected_results[$];

  int errors;
  int samples_sent;
  int results_checked;
  int settings_used;
  int hold_off_cycles;
  bit sender_steady;
  bit receiver_steady;

  battery_level_from_adc_average_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint batch_size();
    longint n;
    n = longint'(shadow_count);
    if (n == 0) n = 1;
    if (n > longint'(MAX_COUNT)) n = longint'(MAX_COUNT);
    return n;
  endfunction

  function automatic longint table_code(input int k);
    logic [WORD_W-1:0] word;
    word = (k < SLOTS) ? shadow_bp_upper : shadow_bp_lower;
    return longint'(word[(k % SLOTS) * SLOT_W +: SAMPLE_BITS]);
  endfunction

  function automatic longint table_capacity(input int k);
    return longint'(shadow_capacity[k * LEVEL_W +: LEVEL_W]);
  endfunction

  // level from the exact mean sum/n: clamp outside the table, interpolate in a segment, else 0
  function automatic logic [LEVEL_W-1:0] battery_level(input longint sum, input longint n);
    longint hi;
    longint lo;
    longint v;
    if (sum >= table_code(0) * n) return LEVEL_W'(table_capacity(0));
    if (sum <= table_code(TABLE_POINTS - 1) * n) return LEVEL_W'(table_capacity(TABLE_POINTS - 1));
    for (int i = 0; i < TABLE_POINTS - 1; i++) begin
      hi = table_code(i) * n;
      lo = table_code(i + 1) * n;
      if (sum < hi && sum >= lo) begin
        v = (sum - lo) * (table_capacity(i) - table_capacity(i + 1)) / (hi - lo)
            + table_capacity(i + 1);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return LEVEL_W'(v);
      end
    end
    return '0;
  endfunction

  function automatic void absorb_sample(input logic [SAMPLE_BITS-1:0] s);
    longint n;
    level_result_t r;
    n = batch_size();
    batch_sum = batch_sum + SUM_W'(s);
    batch_taken = batch_taken + 1'b1;
    if (longint'(batch_taken) >= n) begin
      r.level = battery_level(longint'(batch_sum), n);
      r.average_code = SAMPLE_BITS'(longint'(batch_sum) / n);
      expected_results.push_back(r);
      batch_sum = '0;
      batch_taken = '0;
    end
  endfunction

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'(s);
    do @(posedge clk); while (in_tready !== 1'b1);
    absorb_sample(s);
    samples_sent++;
  endtask

  // stop offering, wait for every pending result, then let the block settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    settings_used++;
    case (idx)
      REG_SAMPLE_COUNT: begin
        shadow_count = value[CNT_W-1:0];
        batch_sum = '0;
        batch_taken = '0;
      end
      REG_BP_UPPER: shadow_bp_upper = value;
      REG_BP_LOWER: shadow_bp_lower = value;
      REG_CAPACITY: shadow_capacity = value;
      default: ;
    endcase
  endtask

  task automatic program_table(input logic [WORD_W-1:0] upper, input logic [WORD_W-1:0] lower,
                               input logic [WORD_W-1:0] caps);
    write_register(REG_BP_UPPER, upper);
    write_register(REG_BP_LOWER, lower);
    write_register(REG_CAPACITY, caps);
  endtask

  // all-zero table after reset: every sample is its own batch at capacity 0
  task automatic test_reset_state();
    send_sample(12'd0);
    send_sample(12'd4095);
  endtask

  task automatic test_table_points();
    program_table({16'd2200, 16'd2457, 16'd2800, 16'd3276},
                  {16'd1000, 16'd1638, 16'd1800, 16'd2000},
                  {8'd0, 8'd5, 8'd20, 8'd40, 8'd60, 8'd80, 8'd90, 8'd100});
    send_sample(12'd4095);
    send_sample(12'd3276);
    send_sample(12'd3000);
    send_sample(12'd2457);
    send_sample(12'd1700);
    send_sample(12'd1638);
    send_sample(12'd1000);
    send_sample(12'd999);
    send_sample(12'd0);
  endtask

  task automatic test_count_handling();
    // only the low 11 bits of the written word count
    write_register(REG_SAMPLE_COUNT, 64'hFFFF_FFFF_FFFF_F803);
    send_sample(12'd2500);
    send_sample(12'd2501);
    send_sample(12'd2502);
    send_sample(12'd4095);
    send_sample(12'd4095);
    send_sample(12'd4095);
    // partial batch, then a count write that throws it away
    send_sample(12'd0);
    send_sample(12'd1);
    write_register(REG_SAMPLE_COUNT, 64'd4);
    send_sample(12'd1);
    send_sample(12'd2);
    send_sample(12'd3);
    send_sample(12'd6);
    write_register(REG_SAMPLE_COUNT, 64'd0);
    send_sample(12'd7);
    send_sample(12'd4094);
    write_register(REG_UNMAPPED_LOW, {$urandom, $urandom});
    write_register(REG_UNMAPPED_HIGH, {$urandom, $urandom});
    send_sample(12'd2048);
  endtask

  task automatic test_odd_tables();
    // rising capacities: negative slope, truncation toward zero
    write_register(REG_CAPACITY, {8'd100, 8'd90, 8'd80, 8'd60, 8'd40, 8'd20, 8'd5, 8'd0});
    send_sample(12'd3000);
    send_sample(12'd2100);
    send_sample(12'd1200);
    // unordered codes with the unused slot bits set
    program_table({16'd500, 16'd3000, 16'd1200, 16'd1000} | 64'hF000_F000_F000_F000,
                  {16'd50, 16'd2000, 16'd100, 16'd4000} | 64'hF000_F000_F000_F000,
                  {$urandom, $urandom});
    send_sample(12'd2500);
    send_sample(12'd4095);
    send_sample(12'd75);
    program_table('1, '1, '1);
    send_sample(12'd4095);
    send_sample(12'd100);
    program_table({16'd2200, 16'd2457, 16'd2800, 16'd3276},
                  {16'd1000, 16'd1638, 16'd1800, 16'd2000},
                  {8'd0, 8'd5, 8'd20, 8'd40, 8'd60, 8'd80, 8'd90, 8'd100});
  endtask

  task automatic test_count_extremes();
    // above range acts as 1024; all-max samples give the largest sum
    write_register(REG_SAMPLE_COUNT, 64'd2047);
    repeat (1024) send_sample(12'd4095);
  endtask

  task automatic test_backpressure();
    write_register(REG_SAMPLE_COUNT, 64'd1);
    hold_off_cycles = HOLD_CYCLES;
    sender_steady = 1'b1;
    repeat (60) send_sample(SAMPLE_BITS'($urandom_range(900, 3400)));
    sender_steady = 1'b0;
  endtask

  task automatic test_random_phases();
    logic [SAMPLE_BITS-1:0] codes[TABLE_POINTS];
    logic [WORD_W-1:0] upper;
    logic [WORD_W-1:0] lower;
    logic [WORD_W-1:0] count_word;
    int step;
    int pick;
    int lo_code;
    int hi_code;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase % 3 != 2) begin
        codes[0] = SAMPLE_BITS'($urandom_range(2500, 4095));
        for (int k = 1; k < TABLE_POINTS; k++) begin
          step = $urandom_range(0, 350);
          codes[k] = (int'(codes[k-1]) > step) ? SAMPLE_BITS'(int'(codes[k-1]) - step) : '0;
        end
      end else begin
        for (int k = 0; k < TABLE_POINTS; k++) codes[k] = SAMPLE_BITS'($urandom);
      end
      upper = {$urandom, $urandom};
      lower = {$urandom, $urandom};
      lo_code = 4095;
      hi_code = 0;
      for (int k = 0; k < TABLE_POINTS; k++) begin
        if (k < SLOTS) upper[k * SLOT_W +: SAMPLE_BITS] = codes[k];
        else lower[(k - SLOTS) * SLOT_W +: SAMPLE_BITS] = codes[k];
        if (int'(codes[k]) < lo_code) lo_code = int'(codes[k]);
        if (int'(codes[k]) > hi_code) hi_code = int'(codes[k]);
      end
      lo_code = (lo_code > 40) ? lo_code - 40 : 0;
      hi_code = (hi_code < 4055) ? hi_code + 40 : 4095;
      count_word = {$urandom, $urandom};
      pick = $urandom_range(0, 9);
      if (pick == 0) count_word[CNT_W-1:0] = '0;
      else if (pick < 7) count_word[CNT_W-1:0] = CNT_W'($urandom_range(1, 6));
      else count_word[CNT_W-1:0] = CNT_W'($urandom_range(7, 40));
      write_register(REG_SAMPLE_COUNT, count_word);
      program_table(upper, lower, {$urandom, $urandom});
      sender_steady = (phase == 4);
      receiver_steady = (phase == 4);
      repeat (PHASE_SAMPLES) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) send_sample($urandom_range(0, 1) ? 12'd4095 : 12'd0);
        else if (pick < 3) send_sample(SAMPLE_BITS'($urandom));
        else send_sample(SAMPLE_BITS'($urandom_range(lo_code, hi_code)));
      end
      sender_steady = 1'b0;
      receiver_steady = 1'b0;
    end
  endtask

  initial begin : result_checker
    int stall;
    level_result_t want;
    logic [LEVEL_W-1:0] got_level;
    logic [SAMPLE_BITS-1:0] got_average;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_off_cycles > 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall = receiver_steady ? 0 : $urandom_range(0, 6);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      got_level   = out_tdata[LEVEL_W-1:0];
      got_average = out_tdata[LEVEL_W +: SAMPLE_BITS];
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction: level %0d average_code %0d",
               got_level, got_average);
        errors++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (got_level !== want.level) begin
          $error("level: expected %0d, got %0d", want.level, got_level);
          errors++;
        end
        if (got_average !== want.average_code) begin
          $error("average_code: expected %0d, got %0d", want.average_code, got_average);
          errors++;
        end
      end
    end
  end

  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    shadow_count = CNT_W'(1);
    shadow_bp_upper = '0;
    shadow_bp_lower = '0;
    shadow_capacity = '0;
    batch_sum = '0;
    batch_taken = '0;
    errors = 0;
    samples_sent = 0;
    results_checked = 0;
    settings_used = 0;
    hold_off_cycles = 0;
    sender_steady = 1'b0;
    receiver_steady = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_table_points();
    test_count_handling();
    test_odd_tables();
    test_count_extremes();
    test_backpressure();
    test_random_phases();
    drain_results();

    $display("Sent %0d samples through %0d register writes; checked %0d level results.",
             samples_sent, settings_used, results_checked);
    $display("Covered table edges, count limits, batch discard, odd tables and a long stall.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
